>>> design/psk_pkg.sv
// ----------------------------------------------------------------------------
// psk_pkg
// Shared types and constants of the partial top-k point selector.
// ----------------------------------------------------------------------------
`default_nettype none

package psk_pkg;

   // field widths fixed by the result and request words
   localparam int INDEX_BITS    = 4;
   localparam int SORT_KEY_BITS = 34;
   localparam int WANTED_BITS   = 4;
   localparam int MODE_BITS     = 2;

   // two point banks: one loading while the other is being sorted
   localparam int NUM_BANKS = 2;

   // ordering modes, anything else orders by distance
   localparam logic [MODE_BITS-1:0] MODE_NEAREST    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LARGEST_X  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_SMALLEST_X = 2'd2;

   // back end hands a point bank back to the front end
   typedef struct packed {
      logic valid;
      logic bank;
   } psk_bank_free_type;

endpackage

`default_nettype wire

>>> design/psk_ram.sv
// ----------------------------------------------------------------------------
// psk_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/psk_queue.sv
// ----------------------------------------------------------------------------
// psk_queue
// Short job queue between the loading front end and the sorting back end.
// ----------------------------------------------------------------------------
`default_nettype none

module psk_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> design/psk_front.sv
// ----------------------------------------------------------------------------
// psk_front
// Loads slot words into a point bank and queues a sort job on the last word.
// ----------------------------------------------------------------------------
`default_nettype none

module psk_front #(
   parameter int MAX_SLOTS  = 11,
   parameter int COORD_BITS = 16,
   localparam int CW    = $clog2(MAX_SLOTS + 1),
   localparam int KAW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
   localparam int PAW   = KAW + 1,
   localparam int PTW   = CW + 2 * COORD_BITS,
   localparam int JOB_W = 1 + 2 * CW + psk_pkg::MODE_BITS + 2 * COORD_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [COORD_BITS-1:0]            point_x,
   input  logic [COORD_BITS-1:0]            point_y,
   input  logic                             point_valid,
   input  logic [COORD_BITS-1:0]            query_x,
   input  logic [COORD_BITS-1:0]            query_y,
   input  logic [psk_pkg::WANTED_BITS-1:0]  wanted_count,
   input  logic [psk_pkg::MODE_BITS-1:0]    mode,
   input  logic                             last_point,
   input  logic                             queue_full,
   input  psk_pkg::psk_bank_free_type       bank_free,
   output logic                             busy,
   output logic                             pt_wr_en,
   output logic [PAW-1:0]                   pt_wr_addr,
   output logic [PTW-1:0]                   pt_wr_data,
   output logic                             job_push,
   output logic [JOB_W-1:0]                 job_data
);

   localparam int CMPW = (CW > psk_pkg::WANTED_BITS) ? CW : psk_pkg::WANTED_BITS;

   logic [CW-1:0]                 valid_count_ff, valid_count_in;
   logic [CW-1:0]                 arrival_slot_ff, arrival_slot_in;
   logic                          wbank_ff, wbank_in;
   logic [psk_pkg::NUM_BANKS-1:0] bank_busy_ff, bank_busy_in;

   logic            slot_open;
   logic            store;
   logic [CW-1:0]   n_now;
   logic [CMPW-1:0] wanted_ext;
   logic [CMPW-1:0] n_ext;
   logic [CW-1:0]   k_now;

   assign busy      = bank_busy_ff[wbank_ff] || queue_full;
   assign slot_open = (arrival_slot_ff < CW'(MAX_SLOTS));
   assign store     = accept && slot_open && point_valid;
   assign n_now     = valid_count_ff + CW'(store);

   // clamp the wanted count to the points actually held
   assign wanted_ext = CMPW'(wanted_count);
   assign n_ext      = CMPW'(n_now);
   assign k_now      = (wanted_ext < n_ext) ? wanted_ext[CW-1:0] : n_now;

   assign pt_wr_en   = store;
   assign pt_wr_addr = {wbank_ff, valid_count_ff[KAW-1:0]};
   assign pt_wr_data = {arrival_slot_ff, point_y, point_x};

   assign job_push = accept && last_point;
   assign job_data = {wbank_ff, n_now, k_now, mode, query_x, query_y};

   always_comb begin
      valid_count_in  = valid_count_ff;
      arrival_slot_in = arrival_slot_ff;
      wbank_in        = wbank_ff;
      bank_busy_in    = bank_busy_ff;
      if (bank_free.valid) begin
         bank_busy_in[bank_free.bank] = 1'b0;
      end
      if (job_push) begin
         valid_count_in          = '0;
         arrival_slot_in         = '0;
         wbank_in                = ~wbank_ff;
         bank_busy_in[wbank_ff]  = 1'b1;
      end else begin
         valid_count_in = n_now;
         if (accept && slot_open) begin
            arrival_slot_in = arrival_slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_count_ff  <= '0;
         arrival_slot_ff <= '0;
         wbank_ff        <= 1'b0;
         bank_busy_ff    <= '0;
      end else begin
         valid_count_ff  <= valid_count_in;
         arrival_slot_ff <= arrival_slot_in;
         wbank_ff        <= wbank_in;
         bank_busy_ff    <= bank_busy_in;
      end
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !queue_full)
      else $error("job pushed into a full queue");

   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      store |-> (valid_count_ff < CW'(MAX_SLOTS)))
      else $error("point stored beyond bank depth");

   a_free_busy_bank: assert property (@(posedge clock) disable iff (reset)
      bank_free.valid |-> bank_busy_ff[bank_free.bank])
      else $error("bank freed that was never handed over");

endmodule

`default_nettype wire

>>> design/psk_back.sv
// ----------------------------------------------------------------------------
// psk_back
// Computes sort keys, runs the partial exchange sort and sends the results.
// ----------------------------------------------------------------------------
`default_nettype none

module psk_back #(
   parameter int MAX_SLOTS  = 11,
   parameter int COORD_BITS = 16,
   localparam int CW    = $clog2(MAX_SLOTS + 1),
   localparam int KAW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
   localparam int PAW   = KAW + 1,
   localparam int PTW   = CW + 2 * COORD_BITS,
   localparam int JOB_W = 1 + 2 * CW + psk_pkg::MODE_BITS + 2 * COORD_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   job_valid,
   input  logic [JOB_W-1:0]                       job_data,
   output logic                                   job_pop,
   output logic [PAW-1:0]                         pt_rd_addr,
   input  logic [PTW-1:0]                         pt_rd_data,
   output psk_pkg::psk_bank_free_type             bank_free,
   output logic                                   rsp_strobe,
   output logic [psk_pkg::INDEX_BITS-1:0]         rsp_slot_index,
   output logic signed [psk_pkg::SORT_KEY_BITS-1:0] rsp_sort_key,
   output logic [psk_pkg::INDEX_BITS-1:0]         rsp_rank,
   output logic [psk_pkg::INDEX_BITS-1:0]         rsp_valid_total,
   output logic                                   rsp_empty_set,
   output logic                                   rsp_last_result
);

   localparam int C    = COORD_BITS;
   localparam int KW   = 2 * C + 2;
   localparam int KRW  = CW + KW;
   localparam int MB   = psk_pkg::MODE_BITS;
   localparam int IB   = psk_pkg::INDEX_BITS;
   localparam int SKB  = psk_pkg::SORT_KEY_BITS;
   // job word offsets: {bank, n, k, mode, qx, qy}
   localparam int MODE_LO = 2 * C;
   localparam int K_LO    = MODE_LO + MB;
   localparam int N_LO    = K_LO + CW;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY_RD,
      ST_KEY_ABS,
      ST_KEY_SQX,
      ST_KEY_SQY,
      ST_KEY_WR,
      ST_SORT_RDI,
      ST_SORT_LDI,
      ST_SORT_RDJ,
      ST_SORT_CMP,
      ST_SORT_WRI,
      ST_OUT_RD,
      ST_OUT_SEND,
      ST_EMPTY
   } state_type;

   state_type               state_ff;
   logic                    bank_ff;
   logic [CW-1:0]           n_ff;
   logic [CW-1:0]           k_ff;
   logic [MB-1:0]           mode_ff;
   logic [C-1:0]            qx_ff;
   logic [C-1:0]            qy_ff;
   logic [CW-1:0]           idx_ff;
   logic [CW-1:0]           jdx_ff;
   logic [C-1:0]            dx_ff;
   logic [C-1:0]            dy_ff;
   logic [C-1:0]            x_ff;
   logic [CW-1:0]           slot_ff;
   logic [2*C-1:0]          sqx_ff;
   logic [2*C-1:0]          sqy_ff;
   logic signed [KW-1:0]    cur_key_ff;
   logic [CW-1:0]           cur_slot_ff;

   logic                    rsp_strobe_ff;
   logic [IB-1:0]           rsp_slot_index_ff;
   logic [SKB-1:0]          rsp_sort_key_ff;
   logic [IB-1:0]           rsp_rank_ff;
   logic [IB-1:0]           rsp_valid_total_ff;
   logic                    rsp_empty_set_ff;
   logic                    rsp_last_result_ff;

   // key store
   logic                    kr_wr_en;
   logic [KAW-1:0]          kr_wr_addr;
   logic [KRW-1:0]          kr_wr_data;
   logic [KAW-1:0]          kr_rd_addr;
   logic [KRW-1:0]          kr_rd_data;

   logic [C-1:0]            px, py;
   logic [CW-1:0]           pslot;
   logic signed [C:0]       diff_x, diff_y;
   logic [C:0]              abs_x, abs_y;
   logic [C-1:0]            mul_op;
   logic [2*C-1:0]          mul_res;
   logic [2*C:0]            dist_sum;
   logic                    use_x;
   logic signed [KW-1:0]    key_new;
   logic signed [KW-1:0]    cand_key;
   logic [CW-1:0]           cand_slot;
   logic                    beats;
   logic [CW-1:0]           idx_next;
   logic [CW-1:0]           jdx_next;
   logic [CW+IB-1:0]        slot_wide, rank_wide, total_wide;
   logic [KW+SKB-1:0]       key_wide;

   psk_ram #(
      .WIDTH (KRW),
      .DEPTH (2 ** KAW)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (kr_wr_en),
      .wr_addr (kr_wr_addr),
      .wr_data (kr_wr_data),
      .rd_addr (kr_rd_addr),
      .rd_data (kr_rd_data)
   );

   assign idx_next = idx_ff + 1'b1;
   assign jdx_next = jdx_ff + 1'b1;

   // point fetch and distance terms
   assign pt_rd_addr = {bank_ff, idx_ff[KAW-1:0]};
   assign px         = pt_rd_data[C-1:0];
   assign py         = pt_rd_data[2*C-1:C];
   assign pslot      = pt_rd_data[PTW-1:2*C];
   assign diff_x     = $signed({px[C-1], px}) - $signed({qx_ff[C-1], qx_ff});
   assign diff_y     = $signed({py[C-1], py}) - $signed({qy_ff[C-1], qy_ff});
   assign abs_x      = diff_x[C] ? 1'b0 - diff_x : diff_x;
   assign abs_y      = diff_y[C] ? 1'b0 - diff_y : diff_y;

   // one squarer shared by both axes
   assign mul_op   = (state_ff == ST_KEY_SQX) ? dx_ff : dy_ff;
   assign mul_res  = (2*C)'(mul_op) * (2*C)'(mul_op);
   assign dist_sum = (2*C+1)'(sqx_ff) + (2*C+1)'(sqy_ff);
   assign use_x    = (mode_ff == psk_pkg::MODE_LARGEST_X) ||
                     (mode_ff == psk_pkg::MODE_SMALLEST_X);
   assign key_new  = use_x ? {{(KW-C){x_ff[C-1]}}, x_ff} : {1'b0, dist_sum};

   assign cand_key  = kr_rd_data[KW-1:0];
   assign cand_slot = kr_rd_data[KRW-1:KW];
   assign beats     = (mode_ff == psk_pkg::MODE_LARGEST_X) ? (cand_key > cur_key_ff)
                                                           : (cand_key < cur_key_ff);

   always_comb begin
      kr_wr_en   = 1'b0;
      kr_wr_addr = idx_ff[KAW-1:0];
      kr_wr_data = {cur_slot_ff, cur_key_ff};
      kr_rd_addr = idx_ff[KAW-1:0];
      unique case (state_ff)
         ST_KEY_WR: begin
            kr_wr_en   = 1'b1;
            kr_wr_data = {slot_ff, key_new};
         end
         ST_SORT_RDJ: begin
            kr_rd_addr = jdx_ff[KAW-1:0];
         end
         ST_SORT_CMP: begin
            // the loser takes position j, the winner stays in hand for position i
            kr_wr_en   = beats;
            kr_wr_addr = jdx_ff[KAW-1:0];
         end
         ST_SORT_WRI: begin
            kr_wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign job_pop = (state_ff == ST_IDLE) && job_valid;

   assign bank_free.valid = (state_ff == ST_EMPTY) ||
                            ((state_ff == ST_OUT_SEND) && (idx_next == n_ff));
   assign bank_free.bank  = bank_ff;

   assign slot_wide  = {{IB{1'b0}}, cand_slot};
   assign rank_wide  = {{IB{1'b0}}, idx_ff};
   assign total_wide = {{IB{1'b0}}, n_ff};
   assign key_wide   = {{SKB{cand_key[KW-1]}}, cand_key};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         jdx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  bank_ff  <= job_data[JOB_W-1];
                  n_ff     <= job_data[N_LO+CW-1:N_LO];
                  k_ff     <= job_data[K_LO+CW-1:K_LO];
                  mode_ff  <= job_data[K_LO-1:MODE_LO];
                  qx_ff    <= job_data[2*C-1:C];
                  qy_ff    <= job_data[C-1:0];
                  idx_ff   <= '0;
                  state_ff <= (job_data[N_LO+CW-1:N_LO] == '0) ? ST_EMPTY : ST_KEY_RD;
               end
            end
            ST_KEY_RD: begin
               state_ff <= ST_KEY_ABS;
            end
            ST_KEY_ABS: begin
               dx_ff    <= abs_x[C-1:0];
               dy_ff    <= abs_y[C-1:0];
               x_ff     <= px;
               slot_ff  <= pslot;
               state_ff <= ST_KEY_SQX;
            end
            ST_KEY_SQX: begin
               sqx_ff   <= mul_res;
               state_ff <= ST_KEY_SQY;
            end
            ST_KEY_SQY: begin
               sqy_ff   <= mul_res;
               state_ff <= ST_KEY_WR;
            end
            ST_KEY_WR: begin
               if (idx_next == n_ff) begin
                  idx_ff   <= '0;
                  state_ff <= (k_ff == '0) ? ST_OUT_RD : ST_SORT_RDI;
               end else begin
                  idx_ff   <= idx_next;
                  state_ff <= ST_KEY_RD;
               end
            end
            ST_SORT_RDI: begin
               state_ff <= ST_SORT_LDI;
            end
            ST_SORT_LDI: begin
               cur_key_ff  <= cand_key;
               cur_slot_ff <= cand_slot;
               jdx_ff      <= idx_next;
               state_ff    <= (idx_next == n_ff) ? ST_SORT_WRI : ST_SORT_RDJ;
            end
            ST_SORT_RDJ: begin
               state_ff <= ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
               if (beats) begin
                  cur_key_ff  <= cand_key;
                  cur_slot_ff <= cand_slot;
               end
               jdx_ff   <= jdx_next;
               state_ff <= (jdx_next == n_ff) ? ST_SORT_WRI : ST_SORT_RDJ;
            end
            ST_SORT_WRI: begin
               if (idx_next == k_ff) begin
                  idx_ff   <= '0;
                  state_ff <= ST_OUT_RD;
               end else begin
                  idx_ff   <= idx_next;
                  state_ff <= ST_SORT_RDI;
               end
            end
            ST_OUT_RD: begin
               state_ff <= ST_OUT_SEND;
            end
            ST_OUT_SEND: begin
               rsp_strobe_ff      <= 1'b1;
               rsp_slot_index_ff  <= slot_wide[IB-1:0];
               rsp_sort_key_ff    <= key_wide[SKB-1:0];
               rsp_rank_ff        <= rank_wide[IB-1:0];
               rsp_valid_total_ff <= total_wide[IB-1:0];
               rsp_empty_set_ff   <= 1'b0;
               rsp_last_result_ff <= (idx_next == n_ff);
               if (idx_next == n_ff) begin
                  idx_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff   <= idx_next;
                  state_ff <= ST_OUT_RD;
               end
            end
            ST_EMPTY: begin
               rsp_strobe_ff      <= 1'b1;
               rsp_slot_index_ff  <= '0;
               rsp_sort_key_ff    <= '0;
               rsp_rank_ff        <= '0;
               rsp_valid_total_ff <= '0;
               rsp_empty_set_ff   <= 1'b1;
               rsp_last_result_ff <= 1'b1;
               state_ff           <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_slot_index  = rsp_slot_index_ff;
   assign rsp_sort_key    = $signed(rsp_sort_key_ff);
   assign rsp_rank        = rsp_rank_ff;
   assign rsp_valid_total = rsp_valid_total_ff;
   assign rsp_empty_set   = rsp_empty_set_ff;
   assign rsp_last_result = rsp_last_result_ff;

   a_k_within_n: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (k_ff <= n_ff))
      else $error("sort depth exceeds stored points");

   a_free_then_last: assert property (@(posedge clock) disable iff (reset)
      bank_free.valid |=> (rsp_strobe_ff && rsp_last_result_ff))
      else $error("bank freed without final word");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (state_ff != ST_IDLE))
      else $error("job popped but sequencer stayed idle");

endmodule

`default_nettype wire

>>> design/partial_select_top_k_points.sv
// sequence: job queued on the last slot word, then taken; keys per point: read, abs diff,
//   square x, square y, write; sort position i < k: read i, compare later ones, write i;
//   results: each word read, then sent; slot words load one per cycle while busy is low;
//   the single key store and its one read port pace the sort; a new set loads into the other point bank meanwhile
// reset: clears slot counters, bank flags, job queue and sequencer; stores are not cleared
// results leave on a one-cycle strobe and cannot be held off by the receiver
// ----------------------------------------------------------------------------
// partial_select_top_k_points
// Top level: slot loader, job queue, point banks and sorting back end.
// ----------------------------------------------------------------------------
`default_nettype none

module partial_select_top_k_points #(
   parameter int MAX_SLOTS  = 11,
   parameter int COORD_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [COORD_BITS-1:0]             req_point_x,
   input  logic signed [COORD_BITS-1:0]             req_point_y,
   input  logic                                     req_point_valid,
   input  logic signed [COORD_BITS-1:0]             req_query_x,
   input  logic signed [COORD_BITS-1:0]             req_query_y,
   input  logic [psk_pkg::WANTED_BITS-1:0]          req_wanted_count,
   input  logic [psk_pkg::MODE_BITS-1:0]            req_mode,
   input  logic                                     req_last_point,
   output logic                                     rsp_strobe,
   output logic [psk_pkg::INDEX_BITS-1:0]           rsp_slot_index,
   output logic signed [psk_pkg::SORT_KEY_BITS-1:0] rsp_sort_key,
   output logic [psk_pkg::INDEX_BITS-1:0]           rsp_rank,
   output logic [psk_pkg::INDEX_BITS-1:0]           rsp_valid_total,
   output logic                                     rsp_empty_set,
   output logic                                     rsp_last_result
);

   localparam int CW    = $clog2(MAX_SLOTS + 1);
   localparam int KAW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int PAW   = KAW + 1;
   localparam int PTW   = CW + 2 * COORD_BITS;
   localparam int JOB_W = 1 + 2 * CW + psk_pkg::MODE_BITS + 2 * COORD_BITS;

   logic                        accept;
   logic                        pt_wr_en;
   logic [PAW-1:0]              pt_wr_addr;
   logic [PTW-1:0]              pt_wr_data;
   logic [PAW-1:0]              pt_rd_addr;
   logic [PTW-1:0]              pt_rd_data;
   logic                        job_push;
   logic [JOB_W-1:0]            job_push_data;
   logic                        job_pop;
   logic [JOB_W-1:0]            job_pop_data;
   logic                        queue_full;
   logic                        queue_empty;
   psk_pkg::psk_bank_free_type  bank_free;

   assign accept = start && !busy;

   psk_front #(
      .MAX_SLOTS  (MAX_SLOTS),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .point_x      (req_point_x),
      .point_y      (req_point_y),
      .point_valid  (req_point_valid),
      .query_x      (req_query_x),
      .query_y      (req_query_y),
      .wanted_count (req_wanted_count),
      .mode         (req_mode),
      .last_point   (req_last_point),
      .queue_full   (queue_full),
      .bank_free    (bank_free),
      .busy         (busy),
      .pt_wr_en     (pt_wr_en),
      .pt_wr_addr   (pt_wr_addr),
      .pt_wr_data   (pt_wr_data),
      .job_push     (job_push),
      .job_data     (job_push_data)
   );

   // two banks of points, selected by the top address bit
   psk_ram #(
      .WIDTH (PTW),
      .DEPTH (2 ** PAW)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   psk_queue #(
      .WIDTH (JOB_W),
      .DEPTH (psk_pkg::NUM_BANKS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .pop       (job_pop),
      .pop_data  (job_pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   psk_back #(
      .MAX_SLOTS  (MAX_SLOTS),
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (!queue_empty),
      .job_data        (job_pop_data),
      .job_pop         (job_pop),
      .pt_rd_addr      (pt_rd_addr),
      .pt_rd_data      (pt_rd_data),
      .bank_free       (bank_free),
      .rsp_strobe      (rsp_strobe),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_sort_key    (rsp_sort_key),
      .rsp_rank        (rsp_rank),
      .rsp_valid_total (rsp_valid_total),
      .rsp_empty_set   (rsp_empty_set),
      .rsp_last_result (rsp_last_result)
   );

endmodule

`default_nettype wire
